### sv/i2cmra_pkg.sv
package i2cmra_pkg;

	// request kinds carried in the slave-side tuser
	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_BURST = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
	localparam logic [1:0] CFG_HALF_TICKS = 2'd1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 16;

	// reset values of the configuration registers
	localparam logic [6:0] SLAVE_ADDR_RST = 7'd83;
	localparam logic [7:0] HALF_TICKS_RST = 8'd1;

	// byte stage of an address / register / data sequence
	typedef enum logic [1:0] {
		STG_ADDR,
		STG_REG,
		STG_PAYLOAD
	} stage_t;

endpackage

### sv/i2c_master_register_access.sv
// Channel  Direction  Handshake                 Payload
// s_*      in         s_tvalid / s_tready       tuser req_type; tdata reg, data, len, sda_in
// m_*      out        m_tvalid / m_tready       tdata line drive and status; tlast rd_last
// cfg_*    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One word in gives one word out; each word is one bus timer tick.
// A word is taken every cycle while the output register is empty or drained in
// that cycle; the bus state update and the result both finish in the accepting cycle.
// A stall on m_tready holds the output register and drops s_tready.
// arst_n clears the bus controller to idle and loads the register reset values.
// cfg_ready is always high; write configuration only while the bus is idle.
module i2c_master_register_access #(
	parameter int MAX_BURST = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [7:0] reg_addr, [15:8] wr_data, [19:16] burst_len, [20] sda_in
	input  logic [i2cmra_pkg::IN_DATA_W-1:0]    s_tdata,
	// [1:0] req_type
	input  logic [i2cmra_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] scl_out, [1] sda_out, [2] busy_res, [3] rd_valid, [11:4] rd_data,
	// [12] nack_seen
	output logic [i2cmra_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [i2cmra_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [i2cmra_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import i2cmra_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START_A,
		PH_START_B,
		PH_TX_LO,
		PH_TX_HI,
		PH_TXACK_LO,
		PH_TXACK_HI,
		PH_RS_A,
		PH_RX_LO,
		PH_RX_HI,
		PH_RXACK_LO,
		PH_RXACK_HI,
		PH_STOP_A,
		PH_STOP_B,
		PH_STOP_C
	} phase_t;

	// configuration
	logic [6:0] slave_addr_q;
	logic [7:0] half_ticks_q;

	// bus state
	phase_t     phase_q,      phase_d;
	logic [3:0] bit_index_q,  bit_index_d;
	logic [7:0] shifter_q,    shifter_d;
	logic [3:0] bytes_left_q, bytes_left_d;
	logic [7:0] tick_timer_q, tick_timer_d;
	logic [1:0] held_kind_q,  held_kind_d;
	logic [7:0] held_reg_q,   held_reg_d;
	logic [7:0] held_data_q,  held_data_d;
	logic       nack_q,       nack_d;
	stage_t     stage_q,      stage_d;

	// unpacked input word
	logic [1:0] req_type;
	logic [7:0] reg_addr;
	logic [7:0] wr_data;
	logic [3:0] burst_len;
	logic       sda_in;

	// result of this tick
	logic       scl, sda, busy, rv, rlast;
	logic [7:0] rdat;
	logic [3:0] n_len;
	logic [8:0] half;
	logic       half_end;
	logic       ackbit;
	logic       take;

	assign req_type  = s_tuser[1:0];
	assign reg_addr  = s_tdata[7:0];
	assign wr_data   = s_tdata[15:8];
	assign burst_len = s_tdata[19:16];
	assign sda_in    = s_tdata[20];

	assign s_tready  = !m_tvalid || m_tready;
	assign cfg_ready = 1'b1;
	assign take      = s_tvalid && s_tready;

	// zero half period acts as one
	assign half     = (half_ticks_q == 8'd0) ? 9'd1 : {1'b0, half_ticks_q};
	assign half_end = ({1'b0, tick_timer_q} + 9'd1) >= half;
	assign ackbit   = bytes_left_q <= 4'd1;

	// clamp burst length to 1..MAX_BURST
	always_comb begin
		n_len = burst_len;
		if (n_len == 4'd0) n_len = 4'd1;
		if ({4'd0, n_len} > MAX_BURST[7:0]) n_len = MAX_BURST[3:0];
	end

	always_comb begin
		phase_d      = phase_q;
		bit_index_d  = bit_index_q;
		shifter_d    = shifter_q;
		bytes_left_d = bytes_left_q;
		tick_timer_d = tick_timer_q;
		held_kind_d  = held_kind_q;
		held_reg_d   = held_reg_q;
		held_data_d  = held_data_q;
		nack_d       = nack_q;
		stage_d      = stage_q;
		scl          = 1'b1;
		sda          = 1'b1;
		busy         = 1'b1;
		rv           = 1'b0;
		rdat         = 8'd0;
		rlast        = 1'b0;

		// line drive from the phase held at the start of the tick
		case (phase_q)
			PH_START_B:  sda = 1'b0;
			PH_TX_LO:    begin scl = 1'b0; sda = shifter_q[7]; end
			PH_TX_HI:    sda = shifter_q[7];
			PH_TXACK_LO: scl = 1'b0;
			PH_RS_A:     scl = 1'b0;
			PH_RX_LO:    scl = 1'b0;
			PH_RXACK_LO: begin scl = 1'b0; sda = ackbit; end
			PH_RXACK_HI: sda = ackbit;
			PH_STOP_A:   begin scl = 1'b0; sda = 1'b0; end
			PH_STOP_B:   sda = 1'b0;
			PH_START_A, PH_TXACK_HI, PH_RX_HI, PH_STOP_C: ;
			default:     busy = 1'b0;
		endcase

		if (!busy) begin
			// idle (or a stray code): take a new request
			phase_d = PH_IDLE;
			if (req_type != REQ_NONE) begin
				held_kind_d  = req_type;
				held_reg_d   = reg_addr;
				held_data_d  = wr_data;
				bytes_left_d = (req_type == REQ_BURST) ? n_len : 4'd1;
				nack_d       = 1'b0;
				stage_d      = STG_ADDR;
				bit_index_d  = 4'd0;
				tick_timer_d = 8'd0;
				phase_d      = PH_START_A;
			end
		end else if (!half_end) begin
			tick_timer_d = tick_timer_q + 8'd1;
		end else begin
			tick_timer_d = 8'd0;
			case (phase_q)
				PH_START_A: phase_d = PH_START_B;
				PH_START_B: begin
					shifter_d   = {slave_addr_q, stage_q == STG_PAYLOAD};
					bit_index_d = 4'd0;
					phase_d     = PH_TX_LO;
				end
				PH_TX_LO: phase_d = PH_TX_HI;
				PH_TX_HI: begin
					shifter_d   = {shifter_q[6:0], 1'b0};
					bit_index_d = bit_index_q + 4'd1;
					phase_d     = (bit_index_d >= 4'd8) ? PH_TXACK_LO : PH_TX_LO;
				end
				PH_TXACK_LO: phase_d = PH_TXACK_HI;
				PH_TXACK_HI: begin
					// record a slave NAK, never abort
					if (sda_in) nack_d = 1'b1;
					bit_index_d = 4'd0;
					if (stage_q == STG_ADDR) begin
						stage_d   = STG_REG;
						shifter_d = held_reg_q;
						phase_d   = PH_TX_LO;
					end else if (stage_q == STG_REG) begin
						stage_d = STG_PAYLOAD;
						if (held_kind_q == REQ_WRITE) begin
							shifter_d = held_data_q;
							phase_d   = PH_TX_LO;
						end else begin
							phase_d = PH_RS_A;
						end
					end else if (held_kind_q == REQ_WRITE) begin
						phase_d = PH_STOP_A;
					end else begin
						shifter_d = 8'd0;
						phase_d   = PH_RX_LO;
					end
				end
				PH_RS_A:  phase_d = PH_START_A;
				PH_RX_LO: phase_d = PH_RX_HI;
				PH_RX_HI: begin
					shifter_d   = {shifter_q[6:0], sda_in};
					bit_index_d = bit_index_q + 4'd1;
					if (bit_index_d >= 4'd8) begin
						rv      = 1'b1;
						rdat    = shifter_d;
						rlast   = ackbit;
						phase_d = PH_RXACK_LO;
					end else begin
						phase_d = PH_RX_LO;
					end
				end
				PH_RXACK_LO: phase_d = PH_RXACK_HI;
				PH_RXACK_HI: begin
					if (bytes_left_q != 4'd0) bytes_left_d = bytes_left_q - 4'd1;
					if (bytes_left_d == 4'd0) begin
						phase_d = PH_STOP_A;
					end else begin
						bit_index_d = 4'd0;
						shifter_d   = 8'd0;
						phase_d     = PH_RX_LO;
					end
				end
				PH_STOP_A: phase_d = PH_STOP_B;
				PH_STOP_B: phase_d = PH_STOP_C;
				default:   phase_d = PH_IDLE;
			endcase
		end
	end

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RST;
			half_ticks_q <= HALF_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_SLAVE_ADDR) slave_addr_q <= cfg_data[6:0];
			else if (cfg_index == CFG_HALF_TICKS) half_ticks_q <= cfg_data;
		end
	end

	// advance the bus state once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_index_q  <= 4'd0;
			shifter_q    <= 8'd0;
			bytes_left_q <= 4'd0;
			tick_timer_q <= 8'd0;
			held_kind_q  <= REQ_NONE;
			held_reg_q   <= 8'd0;
			held_data_q  <= 8'd0;
			nack_q       <= 1'b0;
			stage_q      <= STG_ADDR;
		end else if (take) begin
			phase_q      <= phase_d;
			bit_index_q  <= bit_index_d;
			shifter_q    <= shifter_d;
			bytes_left_q <= bytes_left_d;
			tick_timer_q <= tick_timer_d;
			held_kind_q  <= held_kind_d;
			held_reg_q   <= held_reg_d;
			held_data_q  <= held_data_d;
			nack_q       <= nack_d;
			stage_q      <= stage_d;
		end
	end

	// output register: hold on stall, load the tick's result on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_tready) begin
			m_tvalid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_tdata <= {3'd0, nack_d, rdat, rv, busy, sda, scl};
			m_tlast <= rlast;
		end
	end

endmodule

### bench/i2c_master_register_access_tb.sv
`timescale 1ns / 100ps

module i2c_master_register_access_tb;

	import i2cmra_pkg::*;

	localparam int MAX_BURST    = 8;
	// ticks of random traffic after the directed transfers, a couple of transfers
	localparam int RANDOM_TICKS = 150;
	// ticks pushed between checks of the predicted bus phase
	localparam int CHUNK        = 24;
	// ticks watched at the longest half period, past the end of the first phase
	localparam int SLOW_TICKS   = 269;
	// an index that maps to no register; writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	// bus phases of the master, in the order the controller encodes them
	typedef enum logic [4:0] {
		BUS_IDLE,
		BUS_START_HI,
		BUS_START_LO,
		BUS_TX_LO,
		BUS_TX_HI,
		BUS_TXACK_LO,
		BUS_TXACK_HI,
		BUS_RESTART,
		BUS_RX_LO,
		BUS_RX_HI,
		BUS_RXACK_LO,
		BUS_RXACK_HI,
		BUS_STOP_A,
		BUS_STOP_B,
		BUS_STOP_C
	} bus_phase_t;

	// how the slave side drives SDA over a transfer
	typedef enum logic [1:0] {
		SDA_RANDOM,
		SDA_LOW,
		SDA_HIGH
	} sda_mode_t;

	// one timer tick presented to the master
	typedef struct packed {
		logic [1:0] req;
		logic [7:0] raddr;
		logic [7:0] wdata;
		logic [3:0] len;
		logic       sda;
	} tick_word_t;

	// line drive and status for one tick
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       rd_valid;
		logic [7:0] rd_data;
		logic       rd_last;
		logic       nack;
	} line_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = REQ_NONE;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SLAVE_ADDR;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// ticks waiting for the driver, and line status predicted per accepted tick
	tick_word_t   tick_q[$];
	line_status_t line_status_q[$];

	int pushed_cnt = 0;
	int accepted_cnt = 0;
	int results_cnt = 0;
	int fail_cnt = 0;
	int cycle_cnt = 0;

	// predictor state: a private copy of the master's registers and bus controller
	logic [6:0]  dev_addr = SLAVE_ADDR_RST;
	logic [7:0]  half_per = HALF_TICKS_RST;
	bus_phase_t  bus_phase = BUS_IDLE;
	logic [3:0]  bit_cnt = '0;
	logic [7:0]  shift_reg = '0;
	logic [3:0]  bytes_rem = '0;
	logic [7:0]  tick_cnt = '0;
	logic [1:0]  req_kind = REQ_NONE;
	logic [7:0]  reg_byte = '0;
	logic [7:0]  data_byte = '0;
	logic        nack = 1'b0;
	stage_t      stage = STG_ADDR;

	int send_gap = 0;
	int recv_stall = 0;
	bit send_quiet = 1'b0;
	bit recv_quiet = 1'b0;

	tick_word_t   next_word;
	line_status_t want;
	line_status_t seen;

	i2c_master_register_access #(
		.MAX_BURST(MAX_BURST)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// Advance the private bus controller by one tick and return what the master
	// should drive during it. Line levels come from the phase held at the start
	// of the tick; the nack flag is the one after this tick's update.
	function automatic line_status_t bus_tick(logic [1:0] req, logic [7:0] raddr,
		logic [7:0] wdata, logic [3:0] len, logic sda_i);
		line_status_t r;
		int half;
		logic [3:0] n;
		r = '0;
		r.scl = 1'b1;
		r.sda = 1'b1;
		r.busy = (bus_phase != BUS_IDLE);
		half = (half_per == 0) ? 1 : int'(half_per);
		case (bus_phase)
			BUS_START_LO: r.sda = 1'b0;
			BUS_TX_LO: begin
				r.scl = 1'b0;
				r.sda = shift_reg[7];
			end
			BUS_TX_HI: r.sda = shift_reg[7];
			BUS_TXACK_LO, BUS_RESTART, BUS_RX_LO: r.scl = 1'b0;
			BUS_RXACK_LO: begin
				r.scl = 1'b0;
				r.sda = (bytes_rem <= 1);
			end
			BUS_RXACK_HI: r.sda = (bytes_rem <= 1);
			BUS_STOP_A: begin
				r.scl = 1'b0;
				r.sda = 1'b0;
			end
			BUS_STOP_B: r.sda = 1'b0;
			default: ;
		endcase

		if (bus_phase == BUS_IDLE) begin
			if (req != REQ_NONE) begin
				// latch the request; a zero length counts as one, long bursts saturate
				n = len;
				if (n == 0)
					n = 4'd1;
				if (n > MAX_BURST)
					n = 4'(MAX_BURST);
				req_kind = req;
				reg_byte = raddr;
				data_byte = wdata;
				bytes_rem = (req == REQ_BURST) ? n : 4'd1;
				nack = 1'b0;
				stage = STG_ADDR;
				bit_cnt = '0;
				tick_cnt = '0;
				bus_phase = BUS_START_HI;
			end
		end else if (int'(tick_cnt) + 1 < half) begin
			tick_cnt = tick_cnt + 8'd1;
		end else begin
			tick_cnt = '0;
			case (bus_phase)
				BUS_START_HI: bus_phase = BUS_START_LO;
				BUS_START_LO: begin
					// address byte: read bit only after the repeated start
					shift_reg = {dev_addr, stage == STG_PAYLOAD};
					bit_cnt = '0;
					bus_phase = BUS_TX_LO;
				end
				BUS_TX_LO: bus_phase = BUS_TX_HI;
				BUS_TX_HI: begin
					shift_reg = shift_reg << 1;
					bit_cnt = bit_cnt + 4'd1;
					bus_phase = (bit_cnt >= 8) ? BUS_TXACK_LO : BUS_TX_LO;
				end
				BUS_TXACK_LO: bus_phase = BUS_TXACK_HI;
				BUS_TXACK_HI: begin
					// a high ACK slot is a nack: record it, keep going
					if (sda_i)
						nack = 1'b1;
					bit_cnt = '0;
					if (stage == STG_ADDR) begin
						stage = STG_REG;
						shift_reg = reg_byte;
						bus_phase = BUS_TX_LO;
					end else if (stage == STG_REG) begin
						stage = STG_PAYLOAD;
						if (req_kind == REQ_WRITE) begin
							shift_reg = data_byte;
							bus_phase = BUS_TX_LO;
						end else begin
							bus_phase = BUS_RESTART;
						end
					end else if (req_kind == REQ_WRITE) begin
						bus_phase = BUS_STOP_A;
					end else begin
						shift_reg = '0;
						bus_phase = BUS_RX_LO;
					end
				end
				BUS_RESTART: bus_phase = BUS_START_HI;
				BUS_RX_LO: bus_phase = BUS_RX_HI;
				BUS_RX_HI: begin
					shift_reg = {shift_reg[6:0], sda_i};
					bit_cnt = bit_cnt + 4'd1;
					if (bit_cnt >= 8) begin
						r.rd_valid = 1'b1;
						r.rd_data = shift_reg;
						r.rd_last = (bytes_rem <= 1);
						bus_phase = BUS_RXACK_LO;
					end else begin
						bus_phase = BUS_RX_LO;
					end
				end
				BUS_RXACK_LO: bus_phase = BUS_RXACK_HI;
				BUS_RXACK_HI: begin
					if (bytes_rem > 0)
						bytes_rem = bytes_rem - 4'd1;
					if (bytes_rem == 0) begin
						bus_phase = BUS_STOP_A;
					end else begin
						bit_cnt = '0;
						shift_reg = '0;
						bus_phase = BUS_RX_LO;
					end
				end
				BUS_STOP_A: bus_phase = BUS_STOP_B;
				BUS_STOP_B: bus_phase = BUS_STOP_C;
				default: bus_phase = BUS_IDLE;
			endcase
		end
		r.nack = nack;
		return r;
	endfunction

	// Mostly back to back, sometimes a short pause, rarely a long one.
	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(4, 16);
	endfunction

	function automatic logic pick_sda(sda_mode_t mode);
		case (mode)
			SDA_LOW:  return 1'b0;
			SDA_HIGH: return 1'b1;
			default:  return 1'($urandom_range(0, 1));
		endcase
	endfunction

	task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fail_cnt++;
		end
	endtask

	// Driver: predict on every accepted word, then present the next one after
	// a random gap. Configuration writes update the private copy here too, so
	// prediction and register state move on the same clock edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SLAVE_ADDR: dev_addr = cfg_data[6:0];
					CFG_HALF_TICKS: half_per = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				line_status_q.push_back(bus_tick(s_tuser, s_tdata[7:0], s_tdata[15:8],
					s_tdata[19:16], s_tdata[20]));
				accepted_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					next_word = tick_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= next_word.req;
					// pad bits above sda_in stay zero
					s_tdata <= {3'b000, next_word.sda, next_word.len, next_word.wdata,
						next_word.raddr};
					send_gap = pick_gap(send_quiet);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			// switch now and then into a stretch with no gaps at all
			if ($urandom_range(0, 255) == 0)
				send_quiet = !send_quiet;
		end
	end

	// Monitor: compare each accepted result word with the oldest prediction,
	// and stall the master side at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_cnt++;
				if (line_status_q.size() == 0) begin
					$error("result word with no tick waiting for it");
					fail_cnt++;
				end else begin
					want = line_status_q.pop_front();
					seen.scl = m_tdata[0];
					seen.sda = m_tdata[1];
					seen.busy = m_tdata[2];
					seen.rd_valid = m_tdata[3];
					seen.rd_data = m_tdata[11:4];
					seen.rd_last = m_tlast;
					seen.nack = m_tdata[12];
					check_field("scl_out", 32'(want.scl), 32'(seen.scl));
					check_field("sda_out", 32'(want.sda), 32'(seen.sda));
					check_field("busy_res", 32'(want.busy), 32'(seen.busy));
					check_field("rd_valid", 32'(want.rd_valid), 32'(seen.rd_valid));
					check_field("rd_data", 32'(want.rd_data), 32'(seen.rd_data));
					check_field("rd_last", 32'(want.rd_last), 32'(seen.rd_last));
					check_field("nack_seen", 32'(want.nack), 32'(seen.nack));
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_stall = pick_gap(recv_quiet);
			end
			if ($urandom_range(0, 255) == 0)
				recv_quiet = !recv_quiet;
		end
	end

	// Watchdog: the budget grows with the ticks pushed, far above the worst
	// gap plus stall per word.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > 100 * pushed_cnt + 20000) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic push_tick(logic [1:0] req, logic [7:0] raddr, logic [7:0] wdata,
		logic [3:0] len, logic sda);
		tick_word_t w;
		w.req = req;
		w.raddr = raddr;
		w.wdata = wdata;
		w.len = len;
		w.sda = sda;
		tick_q.push_back(w);
		pushed_cnt++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Reprogram the master once every tick has been taken and every result
	// has come back; the bus is idle at that point.
	task automatic set_config(logic [6:0] addr, logic [7:0] half);
		logic pad;
		wait (accepted_cnt == pushed_cnt);
		wait (results_cnt == accepted_cnt);
		// the spare top bit of the address write must be dropped
		pad = 1'($urandom_range(0, 1));
		write_reg(CFG_SLAVE_ADDR, {pad, addr});
		write_reg(CFG_HALF_TICKS, half);
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_UNMAPPED, 8'($urandom_range(0, 255)));
	endtask

	// Issue one request and keep the clock ticking until the predicted bus is
	// idle again. While the noise lasts, filler ticks carry requests too: those
	// hit a busy master and must be ignored, or start a transfer right behind
	// the one that just ended.
	task automatic run_transfer(logic [1:0] kind, logic [7:0] raddr, logic [7:0] wdata,
		logic [3:0] len, sda_mode_t mode, int noise);
		int chunks;
		logic [1:0] req;
		chunks = 0;
		push_tick(kind, raddr, wdata, len, pick_sda(mode));
		do begin
			repeat (CHUNK) begin
				req = REQ_NONE;
				if (chunks < 8 && $urandom_range(0, 99) < noise)
					req = 2'($urandom_range(1, 3));
				push_tick(req, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					4'($urandom_range(0, 15)), pick_sda(mode));
			end
			chunks++;
			wait (accepted_cnt == pushed_cnt);
		end while (bus_phase != BUS_IDLE);
	endtask

	initial begin
		int rand_start;
		int r;
		int noise;
		sda_mode_t mode;
		logic [6:0] addr;
		logic [7:0] half;

		// hold reset, then release it at an edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A zero half period acts as one tick; address zero on the bus.
		set_config(7'd0, 8'd0);
		write_reg(CFG_UNMAPPED, 8'hFF);
		// write with every slot acked, extreme bytes; stray requests chain behind it
		run_transfer(REQ_WRITE, 8'h00, 8'hFF, 4'd0, SDA_LOW, 50);
		// single read ignores the burst length; slave never acks, reads all ones
		run_transfer(REQ_READ, 8'hFF, 8'h00, 4'd15, SDA_HIGH, 0);
		// burst length zero behaves as one byte
		run_transfer(REQ_BURST, 8'h5A, 8'hA5, 4'd0, SDA_LOW, 0);

		set_config(7'd127, 8'd1);
		// burst length above the maximum saturates; requests thrown at the busy master
		run_transfer(REQ_BURST, 8'hC3, 8'h3C, 4'd15, SDA_RANDOM, 50);

		// Random phases: fresh settings, then one transfer with random content.
		rand_start = pushed_cnt;
		while (pushed_cnt < rand_start + RANDOM_TICKS) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				addr = 7'd0;
			else if (r < 30)
				addr = 7'd127;
			else
				addr = 7'($urandom_range(0, 127));
			r = $urandom_range(0, 99);
			if (r < 10)
				half = 8'd0;
			else if (r < 40)
				half = 8'd2;
			else
				half = 8'd1;
			set_config(addr, half);

			r = $urandom_range(0, 99);
			if (r < 15)
				mode = SDA_LOW;
			else if (r < 20)
				mode = SDA_HIGH;
			else
				mode = SDA_RANDOM;
			noise = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 20) : 0;
			run_transfer(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), mode, noise);
			// a few quiet ticks on the idle bus between transfers
			repeat ($urandom_range(0, 3))
				push_tick(REQ_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
		end

		// Longest half period: start one write and follow it past the end of the
		// first phase; stray requests on the busy master are ignored.
		set_config(7'd83, 8'd255);
		push_tick(REQ_WRITE, 8'h96, 8'h69, 4'd2, 1'b0);
		repeat (SLOW_TICKS)
			push_tick(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), 1'b0);

		// drain: every tick taken, every result back, then let stray words show up
		wait (accepted_cnt == pushed_cnt);
		wait (results_cnt == accepted_cnt);
		repeat (20) @(posedge clk);

		if (fail_cnt == 0 && line_status_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
